FILE: src/assert_macros.svh
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif

`endif

FILE: src/slfr_pkg.sv
package slfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned MaxLenW = 17;
  localparam int unsigned PhaseW  = 3;

  localparam logic [ByteW-1:0] SyncFirst  = 8'hA5;
  localparam logic [ByteW-1:0] SyncSecond = 8'h5A;
  localparam logic [MaxLenW-1:0] HeaderBytes = 17'd4;
  localparam logic [MaxLenW-1:0] MaxFrameRst = 17'd65539;

  localparam logic [PhaseW-1:0] PhSync0 = 3'd0;
  localparam logic [PhaseW-1:0] PhSync1 = 3'd1;
  localparam logic [PhaseW-1:0] PhLenHi = 3'd2;
  localparam logic [PhaseW-1:0] PhLenLo = 3'd3;
  localparam logic [PhaseW-1:0] PhBody  = 3'd4;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_GOOD   = 2'd1,
    ST_BADXOR = 2'd2,
    ST_ABORT  = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             last;
    status_e          status;
  } result_t;

endpackage

FILE: src/sync_length_xor_frame_receiver_core.sv
// Receives one byte per transfer, hunts for the sync pair A5 5A, reads a big-endian
// length and passes every frame byte on; the last byte carries the frame status
// (1 good, 2 checksum mismatch, 3 aborted). Throughput is one byte per cycle while the
// output accepts results; the combinational parser sits between the input register and
// the result register. Stray bytes while hunting produce no result. max_frame_len is
// written through the config channel, which is always ready; write it only while no
// frame is in progress.
module sync_length_xor_frame_receiver_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [slfr_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [slfr_pkg::ByteW-1:0]   frame_byte_o,
  output logic                         last_o,
  output logic [1:0]                   status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [slfr_pkg::MaxLenW-1:0] cfg_data_i
);
  import slfr_pkg::*;
`include "assert_macros.svh"

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             take;
  logic             has_res;
  result_t          res;

  slfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  slfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .byte_i      (s1_byte),
    .take_i      (take),
    .has_res_o   (has_res),
    .res_o       (res)
  );

  slfr_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid),
    .has_res_i    (has_res),
    .res_i        (res),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

  `ASSERT_CLK_RST(a_last_status, clk_i, rst_ni,
    out_valid_o |-> (last_o == (status_o != ST_BUSY)), "last and status disagree")
  `ASSERT_CLK_RST(a_stall_full, clk_i, rst_ni,
    !in_ready_o |-> (s1_valid && out_valid_o && !out_ready_i), "input stalled while not full")
  `ASSERT_CLK_RST(a_take_valid, clk_i, rst_ni,
    take |-> s1_valid, "parser took an empty stage")
endmodule

FILE: src/slfr_in_reg.sv
module slfr_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [slfr_pkg::ByteW-1:0] rx_byte_i,
  input  logic                       take_i,
  output logic                       valid_o,
  output logic [slfr_pkg::ByteW-1:0] byte_o
);
  import slfr_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
endmodule

FILE: src/slfr_parser.sv
module slfr_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [slfr_pkg::MaxLenW-1:0] cfg_data_i,
  input  logic [slfr_pkg::ByteW-1:0]   byte_i,
  input  logic                         take_i,
  output logic                         has_res_o,
  output slfr_pkg::result_t            res_o
);
  import slfr_pkg::*;

  logic [MaxLenW-1:0] max_len_q;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [ByteW-1:0]   len_hi_q, len_hi_d;
  logic [LenW-1:0]    left_q, left_d;
  logic [ByteW-1:0]   xor_q, xor_d;
  logic [LenW-1:0]    len_full;
  logic [LenW-1:0]    left_dec;
  logic [MaxLenW-1:0] total;

  assign cfg_ready_o = 1'b1;
  assign len_full    = {len_hi_q, byte_i};
  assign total       = {1'b0, len_full} + HeaderBytes;
  assign left_dec    = left_q - 1'b1;

  always_comb begin
    phase_d   = phase_q;
    len_hi_d  = len_hi_q;
    left_d    = left_q;
    xor_d     = xor_q;
    has_res_o = 1'b1;
    res_o.frame_byte = byte_i;
    res_o.last       = 1'b0;
    res_o.status     = ST_BUSY;
    case (phase_q)
      PhSync1: begin
        if (byte_i != SyncSecond) begin
          phase_d      = PhSync0;
          xor_d        = '0;
          res_o.last   = 1'b1;
          res_o.status = ST_ABORT;
        end else begin
          xor_d   = xor_q ^ byte_i;
          phase_d = PhLenHi;
        end
      end
      PhLenHi: begin
        len_hi_d = byte_i;
        xor_d    = xor_q ^ byte_i;
        phase_d  = PhLenLo;
      end
      PhLenLo: begin
        if (len_full == '0 || total > max_len_q) begin
          phase_d      = PhSync0;
          xor_d        = '0;
          left_d       = '0;
          res_o.last   = 1'b1;
          res_o.status = ST_ABORT;
        end else begin
          xor_d   = xor_q ^ byte_i;
          left_d  = len_full;
          phase_d = PhBody;
        end
      end
      PhBody: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d      = PhSync0;
          xor_d        = '0;
          res_o.last   = 1'b1;
          res_o.status = (byte_i == xor_q) ? ST_GOOD : ST_BADXOR;
        end else begin
          xor_d = xor_q ^ byte_i;
        end
      end
      default: begin
        phase_d = PhSync0;
        if (byte_i != SyncFirst) begin
          has_res_o = 1'b0;
        end else begin
          xor_d    = byte_i;
          len_hi_d = '0;
          left_d   = '0;
          phase_d  = PhSync1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxFrameRst;
      phase_q   <= PhSync0;
      len_hi_q  <= '0;
      left_q    <= '0;
      xor_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_len_q <= cfg_data_i;
      end
      if (take_i) begin
        phase_q  <= phase_d;
        len_hi_q <= len_hi_d;
        left_q   <= left_d;
        xor_q    <= xor_d;
      end
    end
  end
endmodule

FILE: src/slfr_out_reg.sv
module slfr_out_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       has_res_i,
  input  slfr_pkg::result_t          res_i,
  output logic                       take_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [slfr_pkg::ByteW-1:0] frame_byte_o,
  output logic                       last_o,
  output logic [1:0]                 status_o
);
  import slfr_pkg::*;

  logic    valid_q, valid_d;
  logic    free;
  result_t res_q;

  assign free    = !valid_q || out_ready_i;
  assign take_o  = valid_i && free;
  assign valid_d = free ? (take_o && has_res_i) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign frame_byte_o = res_q.frame_byte;
  assign last_o       = res_q.last;
  assign status_o     = res_q.status;
endmodule

FILE: bench/slfr_frame_checker.sv
module slfr_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [slfr_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [slfr_pkg::ByteW-1:0]   frame_byte_i,
  input  logic                         last_i,
  input  logic [1:0]                   status_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [slfr_pkg::MaxLenW-1:0] cfg_data_i,
  output int unsigned                  errors_o,
  output int unsigned                  pending_o,
  output logic [slfr_pkg::PhaseW-1:0]  phase_o
);
  import slfr_pkg::*;

  logic [PhaseW-1:0]  hunt;
  logic [LenW-1:0]    frame_len;
  logic [LenW-1:0]    body_left;
  logic [ByteW-1:0]   xor_acc;
  logic [MaxLenW-1:0] limit_q;
  result_t            frame_out_q[$];
  result_t            due;
  result_t            next_out;

  assign phase_o = hunt;

  function automatic bit parse_rx_byte(input logic [ByteW-1:0] b, output result_t r);
    logic [MaxLenW-1:0] total;
    r.frame_byte = b;
    r.last = 1'b0;
    r.status = ST_BUSY;
    case (hunt)
      PhSync1: begin
        if (b != SyncSecond) begin
          hunt = PhSync0;
          xor_acc = '0;
          r.last = 1'b1;
          r.status = ST_ABORT;
          return 1'b1;
        end
        xor_acc ^= b;
        hunt = PhLenHi;
      end
      PhLenHi: begin
        frame_len = {b, 8'h00};
        xor_acc ^= b;
        hunt = PhLenLo;
      end
      PhLenLo: begin
        frame_len[7:0] = b;
        xor_acc ^= b;
        total = HeaderBytes + {1'b0, frame_len};
        if (frame_len == '0 || total > limit_q) begin
          hunt = PhSync0;
          xor_acc = '0;
          body_left = '0;
          r.last = 1'b1;
          r.status = ST_ABORT;
        end else begin
          body_left = frame_len;
          hunt = PhBody;
        end
      end
      PhBody: begin
        body_left = body_left - 1'b1;
        if (body_left == '0) begin
          r.last = 1'b1;
          r.status = (b == xor_acc) ? ST_GOOD : ST_BADXOR;
          hunt = PhSync0;
          xor_acc = '0;
        end else begin
          xor_acc ^= b;
        end
      end
      default: begin
        hunt = PhSync0;
        if (b != SyncFirst) return 1'b0;
        xor_acc = b;
        frame_len = '0;
        body_left = '0;
        hunt = PhSync1;
      end
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt = PhSync0;
      frame_len = '0;
      body_left = '0;
      xor_acc = '0;
      limit_q = MaxFrameRst;
      frame_out_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) limit_q = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (frame_out_q.size() == 0) begin
          errors_o++;
          $error("frame byte %02h transferred with nothing due", frame_byte_i);
        end else begin
          due = frame_out_q.pop_front();
          if (frame_byte_i !== due.frame_byte) begin
            errors_o++;
            $error("frame_byte: expected %02h, got %02h", due.frame_byte, frame_byte_i);
          end
          if (last_i !== due.last) begin
            errors_o++;
            $error("last: expected %0d, got %0d", due.last, last_i);
          end
          if (status_i !== due.status) begin
            errors_o++;
            $error("status: expected %0d, got %0d", due.status, status_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (parse_rx_byte(rx_byte_i, next_out)) frame_out_q.push_back(next_out);
      end
      pending_o = frame_out_q.size();
    end
  end

endmodule

FILE: bench/sync_length_xor_frame_receiver_core_tb.sv
module sync_length_xor_frame_receiver_core_tb;
  import slfr_pkg::*;

  localparam int PhaseItems = 190;
  localparam int NumPhases  = 8;
  localparam int QuietPhase = 3;
  localparam int RandPhase  = 6;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic [ByteW-1:0]   rx_byte = '0;
  logic               out_ready = 1'b1;
  logic               cfg_valid = 1'b0;
  logic [MaxLenW-1:0] cfg_data = '0;
  logic               in_ready;
  logic               out_valid;
  logic [ByteW-1:0]   frame_byte;
  logic               last;
  logic [1:0]         status;
  logic               cfg_ready;

  int unsigned        errors;
  int unsigned        pending;
  logic [PhaseW-1:0]  phase;
  bit                 quiet = 1'b0;
  int                 sent;

  int phase_limits[NumPhases] = '{5, 20, 65535, 65539, 4, 6, 0, 259};
  logic [ByteW-1:0] opening_bytes[23] = '{
    8'h00, 8'hFF, SyncSecond,
    SyncFirst, 8'h00,
    SyncFirst, SyncFirst, SyncSecond,
    SyncFirst, SyncSecond, 8'h00, 8'h00,
    SyncFirst, SyncSecond, 8'h00, 8'h01, 8'hFE,
    SyncFirst, SyncSecond, 8'h00, 8'h02, 8'hFF, 8'h00
  };

  sync_length_xor_frame_receiver_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .frame_byte_o (frame_byte),
    .last_o       (last),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  slfr_frame_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .frame_byte_i (frame_byte),
    .last_i       (last),
    .status_i     (status),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .errors_o     (errors),
    .pending_o    (pending),
    .phase_o      (phase)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready <= quiet || ($urandom_range(99) >= 9);
  end

  // entered and left just after a falling edge
  task automatic send_byte(input logic [ByteW-1:0] b);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (!in_ready);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [MaxLenW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // close any open frame, then let the pipeline drain
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (phase != PhSync0) send_byte(8'h00);
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_sequence(input int limit);
    int roll;
    int len;
    int lim;
    int cut;
    logic [LenW-1:0]  len16;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    roll = $urandom_range(99);
    if (roll < 15) begin
      // stray bytes; never leave a sync pair or a trailing first sync byte
      cut = $urandom_range(3, 1);
      b = '0;
      for (int i = 0; i < cut; i++) begin
        sum = b;
        b = 8'($urandom_range(255));
        if ((sum == SyncFirst && b == SyncSecond) || (i == cut - 1 && b == SyncFirst))
          b ^= 8'h01;
        send_byte(b);
      end
      return;
    end
    if (roll < 20) begin
      send_byte(SyncFirst);
      b = 8'($urandom_range(255));
      if (b == SyncSecond) b = SyncFirst;
      send_byte(b);
      return;
    end
    lim = (limit > 4) ? limit - 4 : 0;
    roll = $urandom_range(99);
    if (roll < 8) len = 0;
    else if (roll < 28) len = lim + int'($urandom_range(2)) - 1;
    else if (roll < 33) len = $urandom_range(600, 256);
    else if (roll < 36) len = $urandom_range(65535, 601);
    else len = $urandom_range(24, 1);
    if (roll >= 8 && len < 1) len = 1;
    if (len > 65535) len = 65535;
    if (len > 600 && len <= lim) len = (lim < 65535) ? lim + 1 : $urandom_range(24, 1);
    len16 = len[LenW-1:0];
    sum = SyncFirst ^ SyncSecond ^ len16[15:8] ^ len16[7:0];
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(len16[15:8]);
    send_byte(len16[7:0]);
    if (len == 0 || len + 4 > limit) return;
    if ($urandom_range(99) < 5) begin
      // cut short: following bytes fall into this body
      repeat ($urandom_range(len - 1, 0)) send_byte(8'($urandom_range(255)));
      return;
    end
    repeat (len - 1) begin
      b = 8'($urandom_range(255));
      sum ^= b;
      send_byte(b);
    end
    send_byte(($urandom_range(99) < 80) ? sum : 8'($urandom_range(255)));
  endtask

  initial begin
    int limit;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    settle();
    for (int p = 0; p < NumPhases; p++) begin
      limit = (p == RandPhase) ? $urandom_range(400, 5) : phase_limits[p];
      write_limit(MaxLenW'(limit));
      quiet = (p == QuietPhase);
      sent = 0;
      while (sent < PhaseItems) send_sequence(limit);
      settle();
    end
    quiet = 1'b0;
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("sync_length_xor_frame_receiver_core verification clean");
    end else begin
      $display("sync_length_xor_frame_receiver_core verification failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("sync_length_xor_frame_receiver_core verification failed");
    $finish;
  end

endmodule
